// ===== rtl/core/srpc_pkg.sv =====
// ----------------------------------------------------------------------------
// srpc_pkg
// Shared types, widths and codes of the stepper ramp pulse controller.
// ----------------------------------------------------------------------------
package srpc_pkg;

	localparam int TABLE_DEPTH_DEF = 256;

	localparam int CMD_W    = 3;
	localparam int IDX_W    = 8;
	localparam int PERIOD_W = 32;
	localparam int HOLD_W   = 16;
	localparam int OVR_W    = 16;
	localparam int PULSE_W  = 32;
	localparam int ENTRY_W  = PERIOD_W + HOLD_W;
	localparam int RSTATE_W = 2;

	localparam logic [IDX_W-1:0]   IDX_MAX   = '1;
	localparam logic [HOLD_W-1:0]  HOLD_MAX  = '1;
	localparam logic [OVR_W-1:0]   OVR_MAX   = '1;
	localparam logic [PULSE_W-1:0] PULSE_MAX = '1;

	// Command codes of an input transaction.
	localparam logic [CMD_W-1:0] CMD_TICK        = 3'd0;
	localparam logic [CMD_W-1:0] CMD_START       = 3'd1;
	localparam logic [CMD_W-1:0] CMD_RELEASE     = 3'd2;
	localparam logic [CMD_W-1:0] CMD_STOP        = 3'd3;
	localparam logic [CMD_W-1:0] CMD_SET_TARGET  = 3'd4;
	localparam logic [CMD_W-1:0] CMD_SET_PULSES  = 3'd5;
	localparam logic [CMD_W-1:0] CMD_WRITE_TABLE = 3'd6;
	localparam logic [CMD_W-1:0] CMD_SET_DIR     = 3'd7;

	// Ramp state codes as reported on the result.
	localparam logic [RSTATE_W-1:0] RS_STEADY   = 2'd0;
	localparam logic [RSTATE_W-1:0] RS_ACCEL    = 2'd1;
	localparam logic [RSTATE_W-1:0] RS_DECEL    = 2'd2;
	localparam logic [RSTATE_W-1:0] RS_STOPPING = 2'd3;

	typedef enum logic [3:0] {
		MODE_STEADY   = 4'b0001,
		MODE_ACCEL    = 4'b0010,
		MODE_DECEL    = 4'b0100,
		MODE_STOPPING = 4'b1000
	} mode_t;

	// Status of one transaction after its update, without the table period.
	typedef struct packed {
		logic                running;
		logic [IDX_W-1:0]    speed;
		logic [RSTATE_W-1:0] rstate;
		logic                halted;
		logic                dir;
	} status_t;

	function automatic logic [RSTATE_W-1:0] mode_code(mode_t m);
		logic [RSTATE_W-1:0] c;
		case (m)
			MODE_ACCEL:    c = RS_ACCEL;
			MODE_DECEL:    c = RS_DECEL;
			MODE_STOPPING: c = RS_STOPPING;
			default:       c = RS_STEADY;
		endcase
		return c;
	endfunction

endpackage

// ===== rtl/core/srpc_table_ram.sv =====
// ----------------------------------------------------------------------------
// srpc_table_ram
// Speed table storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module srpc_table_ram #(
	parameter int DEPTH = srpc_pkg::TABLE_DEPTH_DEF,
	parameter int WIDTH = srpc_pkg::ENTRY_W,
	localparam int AW   = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/core/srpc_ramp_core.sv =====
// ----------------------------------------------------------------------------
// srpc_ramp_core
// Ramp state registers and the update applied by each accepted transaction.
// The table is read every cycle at the index the state moves to, so the
// entry of the current index is always ready, forwarded from a write to it.
// ----------------------------------------------------------------------------
module srpc_ramp_core #(
	parameter int TABLE_DEPTH = srpc_pkg::TABLE_DEPTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [srpc_pkg::OVR_W-1:0]       cfg_wdata,
	input  logic                             accept,
	input  logic [srpc_pkg::CMD_W-1:0]       command,
	input  logic [srpc_pkg::IDX_W-1:0]       target_index,
	input  logic [srpc_pkg::PULSE_W-1:0]     pulse_target,
	input  logic [srpc_pkg::IDX_W-1:0]       table_index,
	input  logic [srpc_pkg::PERIOD_W-1:0]    table_period,
	input  logic [srpc_pkg::HOLD_W-1:0]      table_hold,
	input  logic                             direction,
	output srpc_pkg::status_t                status_d,
	output logic [srpc_pkg::PERIOD_W-1:0]    cur_period
);

	localparam int AW = $clog2(TABLE_DEPTH);

	srpc_pkg::mode_t                mode_q, mode_d;
	logic                           run_q, run_d;
	logic                           counted_q, counted_d;
	logic [srpc_pkg::IDX_W-1:0]     cur_q, cur_d;
	logic [srpc_pkg::IDX_W-1:0]     goal_q, goal_d;
	logic [srpc_pkg::HOLD_W-1:0]    hold_q, hold_d;
	logic [srpc_pkg::OVR_W-1:0]     ovr_q, ovr_d;
	logic [srpc_pkg::PULSE_W-1:0]   pdone_q, pdone_d;
	logic [srpc_pkg::PULSE_W-1:0]   pgoal_q, pgoal_d;
	logic                           dir_q, dir_d;
	logic [srpc_pkg::OVR_W-1:0]     stop_ovr_q;

	logic [srpc_pkg::HOLD_W-1:0]    hold_inc, hold_step;
	logic                           elapsed;
	logic [srpc_pkg::IDX_W-1:0]     idx_up, idx_dn;
	logic [srpc_pkg::OVR_W-1:0]     ovr1, ovr2;
	logic [srpc_pkg::PULSE_W-1:0]   pdone_inc;
	logic                           tick_halt;
	logic                           halted;

	logic                           tbl_we;
	logic                           wr_ok, rd_ok;
	logic [AW-1:0]                  waddr, raddr;
	logic [srpc_pkg::ENTRY_W-1:0]   wdata, ram_rdata, entry;
	logic                           fwd_q, rd_ok_q;
	logic [srpc_pkg::ENTRY_W-1:0]   fwd_data_q;
	logic [srpc_pkg::HOLD_W-1:0]    cur_hold;

	// Saturating step values used by the ramp modes and the pulse count.
	assign hold_inc  = (hold_q == srpc_pkg::HOLD_MAX) ? hold_q : hold_q + 1'b1;
	assign elapsed   = (hold_inc >= cur_hold);
	assign hold_step = elapsed ? '0 : hold_inc;
	assign idx_up    = (elapsed && cur_q != srpc_pkg::IDX_MAX) ? cur_q + 1'b1 : cur_q;
	assign idx_dn    = (elapsed && cur_q != '0) ? cur_q - 1'b1 : cur_q;
	assign ovr1      = (ovr_q == srpc_pkg::OVR_MAX) ? ovr_q : ovr_q + 1'b1;
	assign ovr2      = (ovr1 == srpc_pkg::OVR_MAX) ? ovr1 : ovr1 + 1'b1;
	assign pdone_inc = (pdone_q == srpc_pkg::PULSE_MAX) ? pdone_q : pdone_q + 1'b1;

	always_comb begin
		mode_d    = mode_q;
		run_d     = run_q;
		counted_d = counted_q;
		cur_d     = cur_q;
		goal_d    = goal_q;
		hold_d    = hold_q;
		ovr_d     = ovr_q;
		pdone_d   = pdone_q;
		pgoal_d   = pgoal_q;
		dir_d     = dir_q;
		tick_halt = 1'b0;
		halted    = 1'b0;
		tbl_we    = 1'b0;
		if (accept) begin
			case (command)
				srpc_pkg::CMD_TICK: begin
					if (run_q) begin
						case (mode_q)
							srpc_pkg::MODE_ACCEL: begin
								hold_d = hold_step;
								if (idx_up >= goal_q) begin
									cur_d  = goal_q;
									mode_d = srpc_pkg::MODE_STEADY;
								end else begin
									cur_d = idx_up;
								end
							end
							srpc_pkg::MODE_DECEL: begin
								if (idx_dn <= goal_q) begin
									cur_d  = goal_q;
									mode_d = srpc_pkg::MODE_STEADY;
									hold_d = '0;
								end else begin
									cur_d  = idx_dn;
									hold_d = hold_step;
								end
							end
							srpc_pkg::MODE_STOPPING: begin
								ovr_d = ovr1;
								if (ovr1 >= stop_ovr_q) begin
									tick_halt = 1'b1;
								end else begin
									// The overrun budget is spent twice per tick.
									ovr_d  = ovr2;
									cur_d  = idx_dn;
									hold_d = (idx_dn == '0) ? '0 : hold_step;
								end
							end
							default: begin
							end
						endcase
						if (!tick_halt && counted_q) begin
							pdone_d = pdone_inc;
							if (pdone_inc >= pgoal_q) begin
								tick_halt = 1'b1;
							end
						end
						if (tick_halt) begin
							halted    = 1'b1;
							run_d     = 1'b0;
							counted_d = 1'b0;
							cur_d     = '0;
							hold_d    = '0;
							ovr_d     = '0;
							pdone_d   = '0;
							mode_d    = srpc_pkg::MODE_STEADY;
						end
					end
				end
				srpc_pkg::CMD_START: begin
					if (!run_q) begin
						mode_d = srpc_pkg::MODE_ACCEL;
						cur_d  = '0;
						run_d  = 1'b1;
					end else if (cur_q <= goal_q) begin
						mode_d = srpc_pkg::MODE_ACCEL;
					end else begin
						mode_d = srpc_pkg::MODE_DECEL;
					end
				end
				srpc_pkg::CMD_RELEASE: begin
					if (run_q) begin
						goal_d = '0;
						mode_d = srpc_pkg::MODE_DECEL;
					end
				end
				srpc_pkg::CMD_STOP: begin
					if (run_q) begin
						mode_d = srpc_pkg::MODE_STOPPING;
					end
				end
				srpc_pkg::CMD_SET_TARGET: begin
					goal_d = target_index;
				end
				srpc_pkg::CMD_SET_PULSES: begin
					pgoal_d   = pulse_target;
					counted_d = 1'b1;
				end
				srpc_pkg::CMD_WRITE_TABLE: begin
					tbl_we = wr_ok;
				end
				srpc_pkg::CMD_SET_DIR: begin
					dir_d = direction;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= srpc_pkg::MODE_STEADY;
			run_q      <= 1'b0;
			counted_q  <= 1'b0;
			cur_q      <= '0;
			goal_q     <= '0;
			hold_q     <= '0;
			ovr_q      <= '0;
			pdone_q    <= '0;
			pgoal_q    <= '0;
			dir_q      <= 1'b0;
			stop_ovr_q <= '0;
			fwd_q      <= 1'b0;
			rd_ok_q    <= 1'b0;
		end else begin
			mode_q    <= mode_d;
			run_q     <= run_d;
			counted_q <= counted_d;
			cur_q     <= cur_d;
			goal_q    <= goal_d;
			hold_q    <= hold_d;
			ovr_q     <= ovr_d;
			pdone_q   <= pdone_d;
			pgoal_q   <= pgoal_d;
			dir_q     <= dir_d;
			if (cfg_we) begin
				stop_ovr_q <= cfg_wdata;
			end
			fwd_q   <= tbl_we && (waddr == raddr);
			rd_ok_q <= rd_ok;
		end
	end

	// A write to the entry being read in the same cycle is forwarded.
	always_ff @(posedge clk) begin
		fwd_data_q <= wdata;
	end

	assign wr_ok = ({24'd0, table_index} < 32'(TABLE_DEPTH));
	assign rd_ok = ({24'd0, cur_d} < 32'(TABLE_DEPTH));
	assign waddr = AW'(table_index);
	assign raddr = AW'(cur_d);
	assign wdata = {table_period, table_hold};

	srpc_table_ram #(
		.DEPTH (TABLE_DEPTH),
		.WIDTH (srpc_pkg::ENTRY_W)
	) u_table (
		.clk   (clk),
		.we    (tbl_we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (ram_rdata)
	);

	// Indexes beyond the table read as zero.
	assign entry      = !rd_ok_q ? '0 : (fwd_q ? fwd_data_q : ram_rdata);
	assign cur_hold   = entry[srpc_pkg::HOLD_W-1:0];
	assign cur_period = entry[srpc_pkg::ENTRY_W-1:srpc_pkg::HOLD_W];

	assign status_d.running = run_d;
	assign status_d.speed   = cur_d;
	assign status_d.rstate  = srpc_pkg::mode_code(mode_d);
	assign status_d.halted  = halted;
	assign status_d.dir     = dir_d;

	a_idle_steady: assert property (@(posedge clk) disable iff (!arst_n)
		!run_q |-> (mode_q == srpc_pkg::MODE_STEADY && cur_q == '0))
		else $error("motor stopped but ramp not at rest");

	a_count_clear: assert property (@(posedge clk) disable iff (!arst_n)
		!counted_q |-> (pdone_q == '0))
		else $error("pulse count kept outside counted mode");

	a_halt_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && halted) |=> (!run_q && !counted_q && ovr_q == '0 && hold_q == '0))
		else $error("halt left ramp state behind");

	a_fwd_write: assert property (@(posedge clk) disable iff (!arst_n)
		fwd_q |-> $past(accept && command == srpc_pkg::CMD_WRITE_TABLE))
		else $error("forwarding without a table write");

endmodule

// ===== rtl/core/srpc_out_stage.sv =====
// ----------------------------------------------------------------------------
// srpc_out_stage
// Holds each transaction's status in a first stage while the table period is
// read, then in the output register until the receiver takes it.
// ----------------------------------------------------------------------------
module srpc_out_stage (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	output logic                              accept,
	input  srpc_pkg::status_t                 status_d,
	input  logic [srpc_pkg::PERIOD_W-1:0]     cur_period,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [srpc_pkg::PERIOD_W-1:0]     pulse_period,
	output srpc_pkg::status_t                 out_status
);

	logic                            valid_s1;
	srpc_pkg::status_t               status_s1;
	logic                            out_valid_q;
	srpc_pkg::status_t               out_status_q;
	logic [srpc_pkg::PERIOD_W-1:0]   out_period_q;
	logic                            advance;

	assign advance  = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !advance;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				out_valid_q <= valid_s1;
			end
			// An empty first stage still takes a transaction while the output waits.
			if (advance || accept) begin
				valid_s1 <= accept;
			end
		end
	end

	// The read register still holds the entry of this status's index here.
	always_ff @(posedge clk) begin
		if (accept) begin
			status_s1 <= status_d;
		end
		if (advance && valid_s1) begin
			out_status_q <= status_s1;
			out_period_q <= cur_period;
		end
	end

	assign out_valid    = out_valid_q;
	assign out_status   = out_status_q;
	assign pulse_period = out_period_q;

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && out_valid_q && out_stall))
		else $error("input stalled without a blocked result");

endmodule

// ===== rtl/core/stepper_ramp_pulse_controller_top.sv =====
// ----------------------------------------------------------------------------
// stepper_ramp_pulse_controller_top
// Acceleration ramp controller for one stepper channel with a speed table.
// ----------------------------------------------------------------------------
// Status is registered in the first stage, then in the output register.
// One transaction per cycle unless stalled; the table is read once per cycle at
// the next speed index, so the hold and period of the current entry wait ready.
// Reset (arst_n, asynchronous): clears the ramp state, counters and handshake;
// the speed table is not cleared and has no clearing pass.
module stepper_ramp_pulse_controller_top #(
	parameter int TABLE_DEPTH = srpc_pkg::TABLE_DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [srpc_pkg::OVR_W-1:0]        cfg_wdata,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [srpc_pkg::CMD_W-1:0]        command,
	input  logic [srpc_pkg::IDX_W-1:0]        target_index,
	input  logic [srpc_pkg::PULSE_W-1:0]      pulse_target,
	input  logic [srpc_pkg::IDX_W-1:0]        table_index,
	input  logic [srpc_pkg::PERIOD_W-1:0]     table_period,
	input  logic [srpc_pkg::HOLD_W-1:0]       table_hold,
	input  logic                              direction,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [srpc_pkg::PERIOD_W-1:0]     pulse_period,
	output logic [srpc_pkg::PERIOD_W-2:0]     pulse_compare,
	output logic                              running,
	output logic [srpc_pkg::IDX_W-1:0]        speed_index,
	output logic [srpc_pkg::RSTATE_W-1:0]     ramp_state,
	output logic                              just_halted,
	output logic                              dir_out
);

	logic                            accept;
	srpc_pkg::status_t               status_d;
	srpc_pkg::status_t               out_status;
	logic [srpc_pkg::PERIOD_W-1:0]   cur_period;

	srpc_ramp_core #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.accept       (accept),
		.command      (command),
		.target_index (target_index),
		.pulse_target (pulse_target),
		.table_index  (table_index),
		.table_period (table_period),
		.table_hold   (table_hold),
		.direction    (direction),
		.status_d     (status_d),
		.cur_period   (cur_period)
	);

	srpc_out_stage u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.accept       (accept),
		.status_d     (status_d),
		.cur_period   (cur_period),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.pulse_period (pulse_period),
		.out_status   (out_status)
	);

	assign pulse_compare = pulse_period[srpc_pkg::PERIOD_W-1:1];
	assign running       = out_status.running;
	assign speed_index   = out_status.speed;
	assign ramp_state    = out_status.rstate;
	assign just_halted   = out_status.halted;
	assign dir_out       = out_status.dir;

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench for the stepper ramp pulse controller. A queue of
// command transactions (a short directed opening, then random ramp profiles,
// table loads and noise under several stop overrun settings) feeds a driver.
// A monitor keeps its own model of the ramp, predicts one result for each
// accepted transaction, and compares every result field by field.
// ----------------------------------------------------------------------------
module tb_top;
	import srpc_pkg::*;

	localparam int DEPTH       = TABLE_DEPTH_DEF;
	localparam int PHASE_ITEMS = 390;
	localparam int CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic [CMD_W-1:0]    cmd;
		logic [IDX_W-1:0]    target;
		logic [PULSE_W-1:0]  pulses;
		logic [IDX_W-1:0]    entry;
		logic [PERIOD_W-1:0] period;
		logic [HOLD_W-1:0]   hold;
		logic                dir;
	} motor_cmd_t;

	typedef struct packed {
		logic [PERIOD_W-1:0] period;
		logic [PERIOD_W-2:0] compare;
		status_t             status;
	} motor_result_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [OVR_W-1:0]      cfg_wdata = '0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic [CMD_W-1:0]      command = '0;
	logic [IDX_W-1:0]      target_index = '0;
	logic [PULSE_W-1:0]    pulse_target = '0;
	logic [IDX_W-1:0]      table_index = '0;
	logic [PERIOD_W-1:0]   table_period = '0;
	logic [HOLD_W-1:0]     table_hold = '0;
	logic                  direction = 1'b0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic [PERIOD_W-1:0]   pulse_period;
	logic [PERIOD_W-2:0]   pulse_compare;
	logic                  running;
	logic [IDX_W-1:0]      speed_index;
	logic [RSTATE_W-1:0]   ramp_state;
	logic                  just_halted;
	logic                  dir_out;

	stepper_ramp_pulse_controller_top u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.command       (command),
		.target_index  (target_index),
		.pulse_target  (pulse_target),
		.table_index   (table_index),
		.table_period  (table_period),
		.table_hold    (table_hold),
		.direction     (direction),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.pulse_period  (pulse_period),
		.pulse_compare (pulse_compare),
		.running       (running),
		.speed_index   (speed_index),
		.ramp_state    (ramp_state),
		.just_halted   (just_halted),
		.dir_out       (dir_out)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Shadow of the ramp controller.
	logic [RSTATE_W-1:0] mot_mode = RS_STEADY;
	logic                mot_run = 1'b0;
	logic                mot_counted = 1'b0;
	logic [IDX_W-1:0]    mot_speed = '0;
	logic [IDX_W-1:0]    mot_goal = '0;
	logic [HOLD_W-1:0]   mot_hold_cnt = '0;
	logic [OVR_W-1:0]    mot_ovr_cnt = '0;
	logic [OVR_W-1:0]    mot_ovr_limit = '0;
	logic [PULSE_W-1:0]  mot_pulses = '0;
	logic [PULSE_W-1:0]  mot_pulse_goal = '0;
	logic                mot_dir = 1'b0;
	logic [PERIOD_W-1:0] mot_period_tab [DEPTH];
	logic [HOLD_W-1:0]   mot_hold_tab [DEPTH];

	motor_cmd_t    pend_q[$];
	motor_result_t result_q[$];
	motor_cmd_t    drive_cmd;
	motor_result_t want;
	logic          in_took = 1'b0;
	logic          calm = 1'b0;
	int            n_fail = 0;
	int            n_made = 0;
	int            cycle_cnt = 0;

	// Highest index at and below which every table entry has been loaded. Targets are
	// kept within it so that the ramp never lands on an entry never written.
	int            load_top = -1;
	bit            loaded [DEPTH];

	function automatic void halt_motor();
		mot_run      = 1'b0;
		mot_counted  = 1'b0;
		mot_speed    = '0;
		mot_hold_cnt = '0;
		mot_ovr_cnt  = '0;
		mot_pulses   = '0;
		mot_mode     = RS_STEADY;
	endfunction

	function automatic logic hold_expired();
		if (mot_hold_cnt != HOLD_MAX)
			mot_hold_cnt++;
		if (mot_hold_cnt >= mot_hold_tab[mot_speed]) begin
			mot_hold_cnt = '0;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	// One step-pulse tick while running; returns 1 when the motor halts.
	function automatic logic tick_motor();
		case (mot_mode)
			RS_ACCEL: begin
				if (hold_expired() && mot_speed != IDX_MAX)
					mot_speed++;
				if (mot_speed >= mot_goal) begin
					mot_speed = mot_goal;
					mot_mode  = RS_STEADY;
				end
			end
			RS_DECEL: begin
				if (hold_expired() && mot_speed != '0)
					mot_speed--;
				if (mot_speed <= mot_goal) begin
					mot_speed    = mot_goal;
					mot_mode     = RS_STEADY;
					mot_hold_cnt = '0;
				end
			end
			RS_STOPPING: begin
				if (mot_ovr_cnt != OVR_MAX)
					mot_ovr_cnt++;
				if (mot_ovr_cnt >= mot_ovr_limit) begin
					halt_motor();
					return 1'b1;
				end
				// The overrun budget drains two per tick while slowing.
				if (mot_ovr_cnt != OVR_MAX)
					mot_ovr_cnt++;
				if (hold_expired() && mot_speed != '0)
					mot_speed--;
				if (mot_speed == '0)
					mot_hold_cnt = '0;
			end
			default: ;
		endcase
		if (mot_counted) begin
			if (mot_pulses != PULSE_MAX)
				mot_pulses++;
			if (mot_pulses >= mot_pulse_goal) begin
				halt_motor();
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	function automatic motor_result_t advance_motor(motor_cmd_t c);
		motor_result_t r;
		logic          halted;
		halted = 1'b0;
		case (c.cmd)
			CMD_TICK: begin
				if (mot_run)
					halted = tick_motor();
			end
			CMD_START: begin
				if (!mot_run) begin
					mot_mode  = RS_ACCEL;
					mot_speed = '0;
					mot_run   = 1'b1;
				end else if (mot_speed <= mot_goal) begin
					mot_mode = RS_ACCEL;
				end else begin
					mot_mode = RS_DECEL;
				end
			end
			CMD_RELEASE: begin
				if (mot_run) begin
					mot_goal = '0;
					mot_mode = RS_DECEL;
				end
			end
			CMD_STOP: begin
				if (mot_run)
					mot_mode = RS_STOPPING;
			end
			CMD_SET_TARGET: mot_goal = c.target;
			CMD_SET_PULSES: begin
				mot_pulse_goal = c.pulses;
				mot_counted    = 1'b1;
			end
			CMD_WRITE_TABLE: begin
				mot_period_tab[c.entry] = c.period;
				mot_hold_tab[c.entry]   = c.hold;
			end
			default: mot_dir = c.dir;
		endcase
		r.period         = mot_period_tab[mot_speed];
		r.compare        = r.period[PERIOD_W-1:1];
		r.status.running = mot_run;
		r.status.speed   = mot_speed;
		r.status.rstate  = mot_mode;
		r.status.halted  = halted;
		r.status.dir     = mot_dir;
		return r;
	endfunction

	task automatic check_field(input string name, input logic [31:0] exp_v,
			input logic [31:0] act_v);
		if (act_v !== exp_v) begin
			$error("%s: expected %0h, got %0h", name, exp_v, act_v);
			n_fail++;
		end
	endtask

	// Monitor: predicts on each accepted command and checks each result.
	always @(posedge clk) begin
		if (!arst_n) begin
			in_took <= 1'b0;
		end else begin
			in_took <= in_valid && !in_stall;
			if (cfg_we)
				mot_ovr_limit = cfg_wdata;
			if (out_valid && !out_stall) begin
				if (result_q.size() == 0) begin
					$error("result transaction with no prediction pending");
					n_fail++;
				end else begin
					want = result_q.pop_front();
					check_field("pulse_period", want.period, pulse_period);
					check_field("pulse_compare", 32'(want.compare), 32'(pulse_compare));
					check_field("running", 32'(want.status.running), 32'(running));
					check_field("speed_index", 32'(want.status.speed), 32'(speed_index));
					check_field("ramp_state", 32'(want.status.rstate), 32'(ramp_state));
					check_field("just_halted", 32'(want.status.halted), 32'(just_halted));
					check_field("dir_out", 32'(want.status.dir), 32'(dir_out));
				end
			end
			if (in_valid && !in_stall)
				result_q.push_back(advance_motor(motor_cmd_t'({command, target_index,
					pulse_target, table_index, table_period, table_hold, direction})));
		end
	end

	// Driver: a payload is held until its transaction is taken.
	always @(negedge clk) begin
		if (!in_valid || in_took) begin
			if (pend_q.size() != 0 && (calm || $urandom_range(0, 99) >= 29)) begin
				drive_cmd = pend_q.pop_front();
				command      <= drive_cmd.cmd;
				target_index <= drive_cmd.target;
				pulse_target <= drive_cmd.pulses;
				table_index  <= drive_cmd.entry;
				table_period <= drive_cmd.period;
				table_hold   <= drive_cmd.hold;
				direction    <= drive_cmd.dir;
				in_valid     <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		out_stall <= !calm && ($urandom_range(0, 99) < 29);
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	function automatic logic [HOLD_W-1:0] pick_hold();
		int r;
		r = $urandom_range(0, 99);
		if (r < 85)
			return HOLD_W'($urandom_range(0, 3));
		if (r < 98)
			return HOLD_W'($urandom_range(0, 20));
		return HOLD_W'($urandom);
	endfunction

	function automatic logic [IDX_W-1:0] pick_goal();
		int r;
		r = $urandom_range(0, 9);
		if (r < 2)
			return IDX_W'(load_top);
		if (r == 2)
			return '0;
		return IDX_W'($urandom_range(0, load_top));
	endfunction

	// A command with every field random; table writes mostly grow the loaded run.
	function automatic motor_cmd_t fresh(logic [CMD_W-1:0] cmd);
		motor_cmd_t c;
		c.cmd    = cmd;
		c.target = (cmd == CMD_SET_TARGET) ? pick_goal() : IDX_W'($urandom);
		c.pulses = $urandom;
		if (load_top < DEPTH - 1 && $urandom_range(0, 99) < 80)
			c.entry = IDX_W'(load_top + 1);
		else
			c.entry = IDX_W'($urandom);
		c.period = $urandom;
		c.hold   = pick_hold();
		c.dir    = 1'($urandom_range(0, 1));
		return c;
	endfunction

	task automatic queue_cmd(motor_cmd_t c);
		pend_q.push_back(c);
		n_made++;
		if (c.cmd == CMD_WRITE_TABLE) begin
			loaded[c.entry] = 1'b1;
			while (load_top < DEPTH - 1 && loaded[load_top + 1])
				load_top++;
		end
	endtask

	task automatic queue_ticks(int n);
		repeat (n) queue_cmd(fresh(CMD_TICK));
	endtask

	// A ramp profile: set up, start, tick with the odd change, then mostly wind down.
	task automatic gen_profile();
		motor_cmd_t c;
		int         r;
		queue_cmd(fresh(CMD_SET_TARGET));
		if ($urandom_range(0, 99) < 30) begin
			c = fresh(CMD_SET_PULSES);
			if ($urandom_range(0, 3) != 0)
				c.pulses = $urandom_range(0, 60);
			queue_cmd(c);
		end
		if ($urandom_range(0, 99) < 30)
			queue_cmd(fresh(CMD_SET_DIR));
		queue_cmd(fresh(CMD_START));
		repeat ($urandom_range(4, 40)) begin
			r = $urandom_range(0, 99);
			if (r < 85)
				queue_cmd(fresh(CMD_TICK));
			else if (r < 90)
				queue_cmd(fresh(CMD_SET_TARGET));
			else if (r < 94)
				queue_cmd(fresh(CMD_START));
			else if (r < 97)
				queue_cmd(fresh(CMD_SET_DIR));
			else
				queue_cmd(fresh(CMD_WRITE_TABLE));
		end
		r = $urandom_range(0, 99);
		if (r < 35) begin
			queue_cmd(fresh(CMD_RELEASE));
			queue_ticks($urandom_range(2, 20));
		end else if (r < 70) begin
			queue_cmd(fresh(CMD_STOP));
			queue_ticks($urandom_range(2, 30));
		end
	endtask

	task automatic gen_phase(int n_items);
		int stop_at;
		int r;
		stop_at = n_made + n_items;
		while (n_made < stop_at) begin
			r = $urandom_range(0, 99);
			if (r < ((load_top < DEPTH - 1) ? 40 : 15)) begin
				repeat ($urandom_range(4, 20)) queue_cmd(fresh(CMD_WRITE_TABLE));
			end else if (r < 85) begin
				gen_profile();
			end else begin
				repeat ($urandom_range(1, 6))
					queue_cmd(fresh(CMD_W'($urandom_range(0, 7))));
			end
		end
	endtask

	task automatic write_overrun(logic [OVR_W-1:0] v);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we    <= 1'b0;
	endtask

	task automatic drain();
		while (pend_q.size() != 0 || in_valid || result_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	initial begin
		motor_cmd_t       c;
		logic [OVR_W-1:0] overrun_set [5];
		overrun_set = '{16'd0, 16'hFFFF, 16'd1, OVR_W'($urandom), 16'd2};
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		write_overrun(16'd4);

		// Table entries 0 to 3, with the period extremes on the first two.
		c = fresh(CMD_WRITE_TABLE);
		c.entry = 8'd0; c.period = '1; c.hold = '0;
		queue_cmd(c);
		c = fresh(CMD_WRITE_TABLE);
		c.entry = 8'd1; c.period = '0; c.hold = 16'd1;
		queue_cmd(c);
		c = fresh(CMD_WRITE_TABLE);
		c.entry = 8'd2; c.hold = 16'd2;
		queue_cmd(c);
		c = fresh(CMD_WRITE_TABLE);
		c.entry = 8'd3; c.hold = '0;
		queue_cmd(c);
		// Tick, release and stop while the motor is halted change nothing.
		queue_cmd(fresh(CMD_TICK));
		queue_cmd(fresh(CMD_RELEASE));
		queue_cmd(fresh(CMD_STOP));
		c = fresh(CMD_SET_DIR);
		c.dir = 1'b1;
		queue_cmd(c);
		c = fresh(CMD_SET_TARGET);
		c.target = 8'd3;
		queue_cmd(c);
		queue_cmd(fresh(CMD_START));
		queue_ticks(4);
		// Start while running at or below the goal re-enters acceleration.
		queue_cmd(fresh(CMD_START));
		queue_cmd(fresh(CMD_TICK));
		c = fresh(CMD_SET_TARGET);
		c.target = 8'd1;
		queue_cmd(c);
		// Start above the goal turns into deceleration.
		queue_cmd(fresh(CMD_START));
		queue_cmd(fresh(CMD_TICK));
		queue_cmd(fresh(CMD_STOP));
		queue_cmd(fresh(CMD_STOP));
		queue_ticks(3);
		// Counted mode armed while halted still takes effect on the next run.
		c = fresh(CMD_SET_PULSES);
		c.pulses = 32'd2;
		queue_cmd(c);
		queue_cmd(fresh(CMD_START));
		queue_ticks(2);
		queue_cmd(fresh(CMD_START));
		queue_cmd(fresh(CMD_RELEASE));
		queue_cmd(fresh(CMD_TICK));
		drain();

		// The sender holds back between phases until every result is in.
		for (int p = 0; p < 5; p++) begin
			write_overrun(overrun_set[p]);
			calm = (p == 2);
			gen_phase(PHASE_ITEMS);
			drain();
			calm = 1'b0;
		end
		repeat (10) @(posedge clk);

		if (n_fail == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
